/* src/per_bank_fifo_round_robin_scheduler_defines.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef PER_BANK_FIFO_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`define PER_BANK_FIFO_ROUND_ROBIN_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define PBFRR_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbfrr same-cycle check failed");

// Next-cycle implication.
`define PBFRR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbfrr next-cycle check failed");

`endif

/* src/pbfrr_pkg.sv */
// Types and constants of the per-bank FIFO round-robin scheduler.
package pbfrr_pkg;

   localparam int COUNT_MAX = 31;
   localparam int OCC_MAX   = 255;

   typedef enum logic [1:0] {
      KIND_PUSH     = 2'd0,
      KIND_POP      = 2'd1,
      KIND_COMPLETE = 2'd2,
      KIND_RESCHED  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BANK_FULL   = 3'd1,
      ST_BANK_EMPTY  = 3'd2,
      ST_READY_EMPTY = 3'd3,
      ST_READY_FULL  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_DESC = 2'd1,
      S_TAG  = 2'd2
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  bank;
      logic [31:0] request_tag;
      logic        bank_busy;
   } req_type;

   typedef struct packed {
      logic [2:0]  next_bank;
      logic        next_bank_valid;
      logic [31:0] head_tag;
      logic        head_valid;
      logic [4:0]  bank_count;
      logic [7:0]  total_occupancy;
      logic        ready_nonempty;
      status_type  status;
   } rsp_type;

   // Ready queue controls from the sequencer.
   typedef struct packed {
      logic rd;     // fetch the bank at the queue head
      logic push;
      logic pop;
   } rq_ctl_type;

endpackage

/* src/pbfrr_tag_ram.sv */
// Tag storage for all bank queues: one write port, one registered read port.
module pbfrr_tag_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/pbfrr_desc_ram.sv */
// Per-bank descriptor memory (head, tail, fill); entries read as zero until written.
module pbfrr_desc_ram #(
   parameter int N_BANKS = 8,
   parameter int WIDTH = 13,
   localparam int AW = (N_BANKS > 1) ? $clog2(N_BANKS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0]   mem [N_BANKS];
   logic [WIDTH-1:0]   rd_data_ff;
   logic [N_BANKS-1:0] valid_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // never-written bank reads as the reset descriptor
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* src/pbfrr_ready_q.sv */
// Ready-bank FIFO: pointer and fill registers around a small memory.
module pbfrr_ready_q #(
   parameter int DEPTH = 16,
   parameter int BANK_W = 3,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int FW = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pbfrr_pkg::rq_ctl_type  ctl,
   input  logic [BANK_W-1:0]      push_bank,
   output logic [BANK_W-1:0]      head_bank,
   output logic [FW-1:0]          fill
);

   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   logic [BANK_W-1:0] mem [DEPTH];
   logic [BANK_W-1:0] head_bank_ff;
   logic [PW-1:0]     head_ff, head_in;
   logic [PW-1:0]     tail_ff, tail_in;
   logic [FW-1:0]     fill_ff, fill_in;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctl.push) begin
         tail_in = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
         fill_in = fill_ff + 1'b1;
      end else if (ctl.pop) begin
         head_in = (head_ff == LAST) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= push_bank;
      end
      if (ctl.rd) begin
         head_bank_ff <= mem[head_ff];
      end
   end

   assign head_bank = head_bank_ff;
   assign fill      = fill_ff;

endmodule

/* src/per_bank_fifo_round_robin_scheduler.sv */
// Top level: per-bank FIFO scheduler sequencer with descriptor, tag and ready-queue memories.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------
//   request  | req_valid/req_stall | req_data (req_type)
//   response | rsp_valid/rsp_stall | rsp_data (rsp_type)
//
// Each item passes through descriptor read, update and tag read, and result.
// The chain descriptor read -> head pointer update -> tag read forces these steps.
// A finished result sits in the output register; a new item is taken meanwhile,
// and its result waits in the last step while rsp_stall holds the previous one.
// Synchronous reset clears pointers, fills, valid bits and the occupancy count.
`include "per_bank_fifo_round_robin_scheduler_defines.svh"

module per_bank_fifo_round_robin_scheduler #(
   parameter int N_BANKS = 8,
   parameter int BANK_QUEUE_DEPTH = 16,
   parameter int READY_QUEUE_DEPTH = 16,
   parameter int TAG_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pbfrr_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pbfrr_pkg::rsp_type rsp_data
);

   localparam int BANK_W   = (N_BANKS > 1) ? $clog2(N_BANKS) : 1;
   localparam int PTR_W    = (BANK_QUEUE_DEPTH > 1) ? $clog2(BANK_QUEUE_DEPTH) : 1;
   localparam int FILL_W   = $clog2(BANK_QUEUE_DEPTH + 1);
   localparam int RFILL_W  = $clog2(READY_QUEUE_DEPTH + 1);
   localparam int TDEPTH   = N_BANKS * BANK_QUEUE_DEPTH;
   localparam int TADDR_W  = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
   localparam int OCC_W    = $clog2(TDEPTH + 1);
   localparam int DESC_W   = 2 * PTR_W + FILL_W;

   localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(BANK_QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0]  FILL_MAX = FILL_W'(BANK_QUEUE_DEPTH);
   localparam logic [RFILL_W-1:0] RQ_MAX   = RFILL_W'(READY_QUEUE_DEPTH);
   localparam logic [TADDR_W-1:0] ROW_SIZE = TADDR_W'(BANK_QUEUE_DEPTH);

   typedef struct packed {
      logic [PTR_W-1:0]  head;
      logic [PTR_W-1:0]  tail;
      logic [FILL_W-1:0] fill;
   } desc_type;

   pbfrr_pkg::state_type  state_ff, state_in;
   logic                  accept;
   logic [2:0]            bank_wrap;
   logic [BANK_W-1:0]     req_bank;

   pbfrr_pkg::kind_type   kind_ff;
   logic [BANK_W-1:0]     bank_ff;
   logic [TAG_WIDTH-1:0]  tag_ff;
   logic                  busy_ff;

   desc_type              desc_rd, desc_wr;
   logic [FILL_W-1:0]     fill_res_ff;
   pbfrr_pkg::status_type status_in, status_ff;
   logic [BANK_W-1:0]     nb_ff;
   logic                  nbv_in, nbv_ff;
   logic                  fwd_in, fwd_ff;
   logic [OCC_W-1:0]      occ_ff, occ_in;

   logic                  tag_we, tag_re;
   logic [TADDR_W-1:0]    tag_waddr, tag_raddr, row_base;
   logic [TAG_WIDTH-1:0]  tag_rdata, head_raw;

   pbfrr_pkg::rq_ctl_type rq_ctl;
   logic [BANK_W-1:0]     rq_head_bank;
   logic [RFILL_W-1:0]    rq_fill;

   pbfrr_pkg::rsp_type    rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_load;

   assign req_stall = (state_ff != pbfrr_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;

   // bank field folded into range by repeated subtraction
   always_comb begin
      bank_wrap = req_data.bank;
      for (int i = 0; i < 8; i++) begin
         if (int'(bank_wrap) >= N_BANKS) begin
            bank_wrap = bank_wrap - 3'(N_BANKS);
         end
      end
      req_bank = BANK_W'(bank_wrap);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_data.kind;
         bank_ff <= req_bank;
         tag_ff  <= TAG_WIDTH'(req_data.request_tag);
         busy_ff <= req_data.bank_busy;
      end
   end

   pbfrr_desc_ram #(
      .N_BANKS (N_BANKS),
      .WIDTH   (DESC_W)
   ) u_desc_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (state_ff == pbfrr_pkg::S_DESC),
      .wr_addr (bank_ff),
      .wr_data (desc_wr),
      .rd_en   (accept),
      .rd_addr (req_bank),
      .rd_data (desc_rd)
   );

   // Update step: descriptor just read, ready queue head already fetched.
   always_comb begin
      desc_wr   = desc_rd;
      occ_in    = occ_ff;
      status_in = pbfrr_pkg::ST_OK;
      nbv_in    = 1'b0;
      tag_we    = 1'b0;
      rq_ctl.rd   = accept;
      rq_ctl.push = 1'b0;
      rq_ctl.pop  = 1'b0;
      if (state_ff == pbfrr_pkg::S_DESC) begin
         case (kind_ff)
            pbfrr_pkg::KIND_PUSH: begin
               if (desc_rd.fill == FILL_MAX) begin
                  status_in = pbfrr_pkg::ST_BANK_FULL;
               end else begin
                  tag_we       = 1'b1;
                  desc_wr.tail = (desc_rd.tail == PTR_LAST) ? '0 : desc_rd.tail + 1'b1;
                  desc_wr.fill = desc_rd.fill + 1'b1;
                  occ_in       = occ_ff + 1'b1;
                  if (desc_rd.fill == '0 && !busy_ff) begin
                     if (rq_fill == RQ_MAX) begin
                        status_in = pbfrr_pkg::ST_READY_FULL;
                     end else begin
                        rq_ctl.push = 1'b1;
                     end
                  end
               end
            end
            pbfrr_pkg::KIND_POP: begin
               if (rq_fill == '0) begin
                  status_in = pbfrr_pkg::ST_READY_EMPTY;
               end else begin
                  nbv_in     = 1'b1;
                  rq_ctl.pop = 1'b1;
               end
            end
            pbfrr_pkg::KIND_COMPLETE: begin
               if (desc_rd.fill == '0) begin
                  status_in = pbfrr_pkg::ST_BANK_EMPTY;
               end else begin
                  desc_wr.head = (desc_rd.head == PTR_LAST) ? '0 : desc_rd.head + 1'b1;
                  desc_wr.fill = desc_rd.fill - 1'b1;
                  occ_in       = occ_ff - 1'b1;
               end
            end
            pbfrr_pkg::KIND_RESCHED: begin
               if (desc_rd.fill == '0) begin
                  status_in = pbfrr_pkg::ST_BANK_EMPTY;
               end else if (rq_fill == RQ_MAX) begin
                  status_in = pbfrr_pkg::ST_READY_FULL;
               end else begin
                  rq_ctl.push = 1'b1;
               end
            end
            default: begin
               status_in = pbfrr_pkg::ST_OK;
            end
         endcase
      end
   end

   assign row_base  = TADDR_W'(bank_ff) * ROW_SIZE;
   assign tag_waddr = row_base + TADDR_W'(desc_rd.tail);
   assign tag_raddr = row_base + TADDR_W'(desc_wr.head);
   assign tag_re    = (state_ff == pbfrr_pkg::S_DESC);
   // push onto an empty queue writes the entry that is read back as head
   assign fwd_in    = tag_we && (tag_waddr == tag_raddr);

   pbfrr_tag_ram #(
      .DEPTH (TDEPTH),
      .WIDTH (TAG_WIDTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_waddr),
      .wr_data (tag_ff),
      .rd_en   (tag_re),
      .rd_addr (tag_raddr),
      .rd_data (tag_rdata)
   );

   pbfrr_ready_q #(
      .DEPTH  (READY_QUEUE_DEPTH),
      .BANK_W (BANK_W)
   ) u_ready_q (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rq_ctl),
      .push_bank (bank_ff),
      .head_bank (rq_head_bank),
      .fill      (rq_fill)
   );

   always_ff @(posedge clock) begin
      if (state_ff == pbfrr_pkg::S_DESC) begin
         fill_res_ff <= desc_wr.fill;
         status_ff   <= status_in;
         nb_ff       <= nbv_in ? rq_head_bank : '0;
         nbv_ff      <= nbv_in;
         fwd_ff      <= fwd_in;
      end
   end

   assign head_raw = fwd_ff ? tag_ff : tag_rdata;
   assign out_load = (state_ff == pbfrr_pkg::S_TAG) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_in.next_bank       = 3'(nb_ff);
      rsp_in.next_bank_valid = nbv_ff;
      rsp_in.head_tag        = (fill_res_ff != '0) ? 32'(head_raw) : '0;
      rsp_in.head_valid      = (fill_res_ff != '0);
      rsp_in.bank_count      = (int'(fill_res_ff) > pbfrr_pkg::COUNT_MAX) ?
                               5'(pbfrr_pkg::COUNT_MAX) : 5'(fill_res_ff);
      rsp_in.total_occupancy = (int'(occ_ff) > pbfrr_pkg::OCC_MAX) ?
                               8'(pbfrr_pkg::OCC_MAX) : 8'(occ_ff);
      rsp_in.ready_nonempty  = (rq_fill != '0);
      rsp_in.status          = status_ff;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbfrr_pkg::S_IDLE: begin
            if (accept) begin
               state_in = pbfrr_pkg::S_DESC;
            end
         end
         pbfrr_pkg::S_DESC: begin
            state_in = pbfrr_pkg::S_TAG;
         end
         pbfrr_pkg::S_TAG: begin
            if (out_load) begin
               state_in = pbfrr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pbfrr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbfrr_pkg::S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PBFRR_ASSERT_IMPL(a_pop_status, clock, reset,
      rsp_valid && rsp_data.next_bank_valid, rsp_data.status == pbfrr_pkg::ST_OK)
   `PBFRR_ASSERT_IMPL(a_head_count, clock, reset,
      rsp_valid, rsp_data.head_valid == (rsp_data.bank_count != 5'd0))
   `PBFRR_ASSERT_NEXT(a_occ_step, clock, reset, state_ff == pbfrr_pkg::S_DESC,
      (occ_ff == $past(occ_ff)) || (occ_ff == $past(occ_ff) + 1'b1) ||
      (occ_ff == $past(occ_ff) - 1'b1))
   `PBFRR_ASSERT_IMPL(a_rq_bound, clock, reset, 1'b1, rq_fill <= RQ_MAX)

endmodule
